// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qes_pkg.sv =====
// types, constants and step functions of the quadratic solver
package qes_pkg;

  localparam int CW     = 16;
  localparam int FB     = 16;
  localparam int SQ_W   = 33;
  localparam int RAD_W  = 2 * SQ_W;
  localparam int REM_W  = SQ_W + 4;
  localparam int BASE_W = CW + FB + 1;
  localparam int DEN_W  = CW + 1;
  localparam int NUM_W  = BASE_W + 2;
  localparam int ROOT_W = 33;
  localparam int D_W    = 2 * CW + 2;

  typedef enum logic [2:0] {
    CLS_QUAD_NONE = 3'd0,
    CLS_QUAD_ONE  = 3'd1,
    CLS_QUAD_TWO  = 3'd2,
    CLS_LIN_NONE  = 3'd3,
    CLS_LIN_ONE   = 3'd4,
    CLS_LIN_INF   = 3'd5
  } root_class_t;

  typedef struct packed {
    root_class_t              cls;
    logic signed [BASE_W-1:0] base;
    logic                     den_neg;
    logic [DEN_W-1:0]         den_mag;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [RAD_W-1:0] op;
    logic [REM_W-1:0] rem;
    logic [SQ_W-1:0]  root;
  } sq_data_t;

  typedef struct packed {
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] rem;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    root_class_t      cls;
    logic [DEN_W-1:0] den_mag;
    div_lane_t        lo;
    div_lane_t        hi;
  } div_data_t;

  function automatic sq_data_t sq_step(input sq_data_t d);
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    sq_data_t         r;
    sh    = {d.rem[REM_W-3:0], d.op[RAD_W-1 -: 2]};
    trial = {{(REM_W-SQ_W-2){1'b0}}, d.root, 2'b01};
    ge    = (sh >= trial);
    r      = d;
    r.rem  = ge ? (sh - trial) : sh;
    r.root = {d.root[SQ_W-2:0], ge};
    r.op   = {d.op[RAD_W-3:0], 2'b00};
    return r;
  endfunction

  function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] m);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;
    div_lane_t      r;
    sh   = {l.rem, l.nq[NUM_W-1]};
    diff = sh - {1'b0, m};
    ge   = (sh >= {1'b0, m});
    r     = l;
    r.rem = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    r.nq  = {l.nq[NUM_W-2:0], ge};
    return r;
  endfunction

endpackage

// ===== hw/rtl/qes_front.sv =====
// front cells: products, discriminant, class and divider operands
module qes_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [qes_pkg::CW-1:0] coef_square,
  input  logic [qes_pkg::CW-1:0] coef_linear,
  input  logic [qes_pkg::CW-1:0] coef_constant,
  output logic                out_valid,
  output qes_pkg::sq_data_t   out_data
);
  import qes_pkg::*;

  logic                     va_r;
  logic [CW-1:0]            a_r, b_r, c_r;
  logic signed [2*CW-1:0]   bb_r, ac_r;
  logic signed [2*CW-1:0]   bb_nxt, ac_nxt;
  logic                     vb_r;
  sq_data_t                 data_r, data_nxt;
  logic signed [D_W-1:0]    disc;
  root_class_t              cls;
  logic [DEN_W-1:0]         den, neg_src;
  logic [SQ_W-1:0]          rad;

  assign bb_nxt = $signed(coef_linear) * $signed(coef_linear);
  assign ac_nxt = $signed(coef_square) * $signed(coef_constant);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= coef_square;
      b_r    <= coef_linear;
      c_r    <= coef_constant;
      bb_r   <= bb_nxt;
      ac_r   <= ac_nxt;
      data_r <= data_nxt;
    end
  end

  assign disc = {{2{bb_r[2*CW-1]}}, bb_r} - {ac_r, 2'b00};

  always_comb begin
    if (a_r == '0) begin
      if (b_r == '0) cls = (c_r == '0) ? CLS_LIN_INF : CLS_LIN_NONE;
      else           cls = CLS_LIN_ONE;
    end else if (disc[D_W-1]) begin
      cls = CLS_QUAD_NONE;
    end else if (disc == '0) begin
      cls = CLS_QUAD_ONE;
    end else begin
      cls = CLS_QUAD_TWO;
    end
  end

  always_comb begin
    neg_src = (a_r == '0) ? {c_r[CW-1], c_r} : {b_r[CW-1], b_r};
    den     = (a_r == '0) ? {b_r[CW-1], b_r} : {a_r, 1'b0};
    rad     = (cls == CLS_QUAD_TWO) ? disc[SQ_W-1:0] : '0;
    data_nxt              = '0;
    data_nxt.ctl.cls      = cls;
    data_nxt.ctl.base     = {DEN_W'(-neg_src), {FB{1'b0}}};
    data_nxt.ctl.den_neg  = den[DEN_W-1];
    data_nxt.ctl.den_mag  = den[DEN_W-1] ? DEN_W'(-den) : den;
    data_nxt.op           = {1'b0, rad, {(2*FB){1'b0}}};
  end

  assign out_valid = vb_r;
  assign out_data  = data_r;
endmodule

// ===== hw/rtl/qes_sqrt_cell.sv =====
// one cell of the square root chain, one root bit per cell
module qes_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  qes_pkg::sq_data_t in_data,
  output logic              out_valid,
  output qes_pkg::sq_data_t out_data
);
  import qes_pkg::*;

  logic     valid_r;
  sq_data_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  valid_r <= 1'b0;
    else if (en) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= sq_step(in_data);
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

// ===== hw/rtl/qes_div_cell.sv =====
// one cell of the divider chain, one quotient bit per cell for both roots
module qes_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  qes_pkg::div_data_t in_data,
  output logic               out_valid,
  output qes_pkg::div_data_t out_data
);
  import qes_pkg::*;

  logic      valid_r;
  div_data_t data_r, data_nxt;

  always_comb begin
    data_nxt    = in_data;
    data_nxt.lo = div_step(in_data.lo, in_data.den_mag);
    data_nxt.hi = div_step(in_data.hi, in_data.den_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  valid_r <= 1'b0;
    else if (en) valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

// ===== hw/rtl/quadratic_equation_solver.sv =====
// pipeline from input beat to output beat: 2 front, 33 sqrt, 1 prep, 35 div, 1 out register stages
// one beat per cycle unless stalled; one root bit per sqrt cell, one quotient bit per div cell
// the whole chain holds while the output register waits on out_tready
// reset: synchronous active-low rst_n clears the valid bits only
// no stored state between beats
module quadratic_equation_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coef_square, coef_linear, coef_constant
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // root_class, first_root, second_root, zero pad
);
  import qes_pkg::*;

  `include "assert_macros.svh"

  localparam int NSQ  = SQ_W;
  localparam int NDIV = NUM_W;

  logic      adv;
  logic      sq_v [NSQ+1];
  sq_data_t  sq_d [NSQ+1];
  logic      dv_v [NDIV+1];
  div_data_t dv_d [NDIV+1];
  logic      prep_v_r;
  div_data_t prep_r, prep_nxt;
  logic      out_valid_r;
  logic [71:0] out_data_r, out_data_nxt;

  logic                  inexact;
  logic signed [NUM_W-1:0] base_x, s_x, p_lo, p_hi;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  qes_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_valid      (in_tvalid),
    .coef_square   (in_tdata[15:0]),
    .coef_linear   (in_tdata[31:16]),
    .coef_constant (in_tdata[47:32]),
    .out_valid     (sq_v[0]),
    .out_data      (sq_d[0])
  );

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    qes_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_v[i]),
      .in_data   (sq_d[i]),
      .out_valid (sq_v[i+1]),
      .out_data  (sq_d[i+1])
    );
  end

  function automatic div_lane_t make_lane(input logic signed [NUM_W-1:0] p,
                                          input logic inx, input logic den_neg);
    div_lane_t l;
    l.rem = '0;
    l.neg = p[NUM_W-1] ^ den_neg;
    l.nq  = p[NUM_W-1] ? NUM_W'(-p - NUM_W'(inx)) : p;
    return l;
  endfunction

  always_comb begin
    inexact = |sq_d[NSQ].rem;
    base_x  = {{(NUM_W-BASE_W){sq_d[NSQ].ctl.base[BASE_W-1]}}, sq_d[NSQ].ctl.base};
    s_x     = {{(NUM_W-SQ_W){1'b0}}, sq_d[NSQ].root};
    p_lo    = base_x - s_x - NUM_W'(inexact);
    p_hi    = base_x + s_x;
    prep_nxt.cls     = sq_d[NSQ].ctl.cls;
    prep_nxt.den_mag = sq_d[NSQ].ctl.den_mag;
    prep_nxt.lo      = make_lane(p_lo, inexact, sq_d[NSQ].ctl.den_neg);
    prep_nxt.hi      = make_lane(p_hi, inexact, sq_d[NSQ].ctl.den_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   prep_v_r <= 1'b0;
    else if (adv) prep_v_r <= sq_v[NSQ];
  end

  always_ff @(posedge clk) begin
    if (adv) prep_r <= prep_nxt;
  end

  assign dv_v[0] = prep_v_r;
  assign dv_d[0] = prep_r;

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    qes_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_v[j]),
      .in_data   (dv_d[j]),
      .out_valid (dv_v[j+1]),
      .out_data  (dv_d[j+1])
    );
  end

  function automatic logic [ROOT_W-1:0] sat_root(input div_lane_t l);
    logic [NUM_W-1:0] lim;
    logic [ROOT_W-1:0] r;
    lim = {{(NUM_W-ROOT_W){1'b0}}, 1'b1, {(ROOT_W-1){1'b0}}};
    if (l.neg) r = (l.nq > lim) ? {1'b1, {(ROOT_W-1){1'b0}}} : ROOT_W'(-l.nq);
    else       r = (l.nq >= lim) ? {1'b0, {(ROOT_W-1){1'b1}}} : l.nq[ROOT_W-1:0];
    return r;
  endfunction

  always_comb begin
    logic [ROOT_W-1:0] r1, r2;
    root_class_t       cls;
    cls = dv_d[NDIV].cls;
    r1  = '0;
    r2  = '0;
    if (cls == CLS_QUAD_ONE || cls == CLS_QUAD_TWO || cls == CLS_LIN_ONE) begin
      r1 = sat_root(dv_d[NDIV].lo);
    end
    if (cls == CLS_QUAD_TWO) begin
      r2 = sat_root(dv_d[NDIV].hi);
    end
    out_data_nxt = {3'b000, r2, r1, cls};
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_v[NDIV];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_IMPLIES(a_noroot_zero, out_tvalid && (out_tdata[2:0] == CLS_QUAD_NONE || out_tdata[2:0] == CLS_LIN_NONE || out_tdata[2:0] == CLS_LIN_INF), out_tdata[68:3] == '0, "root field set for a rootless class")
  `ASSERT_IMPLIES(a_second_zero, out_tvalid && out_tdata[2:0] != CLS_QUAD_TWO, out_tdata[68:36] == '0, "second root set outside two-root class")
  `ASSERT_NEXT(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready || !out_tvalid || $stable(out_tdata), "output beat changed while stalled")
endmodule
